// ===== design/atts_pkg.sv =====
// Shared constants for the arctangent Taylor series unit.
package atts_pkg;
	localparam int X_WIDTH = 32;
	localparam int ANGLE_WIDTH = 18;
	localparam int S_TDATA_WIDTH = 32;
	localparam int M_TDATA_WIDTH = 24;
	localparam longint PI_HALF_Q32 = 64'd6746518852;
	localparam longint ANGLE_MAX = 131071;
	localparam longint ANGLE_MIN = -131072;
endpackage

// ===== design/arctangent_taylor_series_unit.sv =====
// Top level of the pipelined fixed-point arctangent unit.
// The unit takes one signed Q15.16 argument per beat on the s_ channel and
// returns its arctangent in radians on the m_ channel, one result per beat,
// in the order the arguments came in.
// Arguments above one in magnitude are first turned into their reciprocal by
// a restoring divider that resolves one quotient bit per stage, so it spans
// FRACTION_BITS stages. One stage then squares the reduced value, one stage
// per series term forms the next power and term, a final stage closes the sum,
// and the output register adds the pi/2 offset and saturates.
// Throughput is one beat per cycle while the receiver does not stall; the unit has no state between items.
// Each stage holds its item until the next stage frees, so a stalled
// receiver fills the pipeline gradually and s_tready falls only when every
// stage holds a waiting item. Reset empties the pipeline.
module arctangent_taylor_series_unit #(
	parameter int SERIES_TERMS = 10,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [atts_pkg::S_TDATA_WIDTH-1:0]  s_tdata,   // [31:0] x_value
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [atts_pkg::M_TDATA_WIDTH-1:0]  m_tdata    // [17:0] angle, rest zero
);
	import atts_pkg::*;

	localparam int F = FRACTION_BITS;
	localparam int T = SERIES_TERMS;
	localparam int L = F + T + 4;
	localparam int EW = (F + 4 > ANGLE_WIDTH) ? F + 4 : ANGLE_WIDTH;
	localparam longint ONE = 64'd1 << F;
	localparam longint PI_HALF = (PI_HALF_Q32 + (64'd1 << (31 - F))) >> (32 - F);
	localparam logic signed [EW-1:0] PI_W = EW'(PI_HALF);
	localparam logic signed [EW-1:0] MAX_W = EW'(ANGLE_MAX);
	localparam logic signed [EW-1:0] MIN_W = EW'(ANGLE_MIN);
	localparam logic [X_WIDTH:0] ONE_M = (X_WIDTH + 1)'(ONE);
	localparam logic [F:0] ONE_P = (F + 1)'(ONE);

	typedef struct packed {
		logic                big;
		logic                neg;
		logic [X_WIDTH:0]    mag;
		logic [X_WIDTH:0]    rem;
		logic [F-1:0]        q;
		logic signed [F+1:0] xd;
	} div_t;

	typedef struct packed {
		logic                big;
		logic                neg;
		logic                vneg;
		logic [F:0]          pm;
		logic [F:0]          v2;
		logic [F:0]          tm;
		logic signed [F+2:0] sum;
	} ser_t;

	logic [L-1:0] vld_q;
	logic [L-1:0] en;
	div_t div_s [F+1];
	ser_t ser_s [T+2];
	logic [ANGLE_WIDTH-1:0] angle_q;

	logic signed [X_WIDTH-1:0] x_in;
	logic [X_WIDTH:0] x_mag;

	always_comb begin
		en[L-1] = !vld_q[L-1] || m_tready;
		for (int k = L - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[L-1];
	assign m_tdata = {{(M_TDATA_WIDTH - ANGLE_WIDTH){1'b0}}, angle_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < L; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_comb begin
		x_in = signed'(s_tdata[X_WIDTH-1:0]);
		x_mag = x_in[X_WIDTH-1] ? (X_WIDTH + 1)'(-{1'b1, x_in})
		                        : {1'b0, s_tdata[X_WIDTH-1:0]};
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			div_s[0].neg <= x_in[X_WIDTH-1];
			div_s[0].mag <= x_mag;
			div_s[0].big <= (x_mag > ONE_M);
			div_s[0].rem <= ONE_M;
			div_s[0].q <= '0;
			div_s[0].xd <= x_in[F+1:0];
		end
	end

	for (genvar k = 1; k <= F; k++) begin : g_div
		logic [X_WIDTH:0] rem_next;
		logic qbit;
		div_t div_nxt;

		atts_div_step u_step (
			.rem      (div_s[k-1].rem),
			.mag      (div_s[k-1].mag),
			.rem_next (rem_next),
			.qbit     (qbit)
		);

		always_comb begin
			div_nxt = div_s[k-1];
			div_nxt.rem = rem_next;
			div_nxt.q = {div_s[k-1].q[F-2:0], qbit};
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				div_s[k] <= div_nxt;
			end
		end
	end

	logic [F:0] v_mag;
	logic v_neg;
	logic [2*F+1:0] sq;

	always_comb begin
		if (div_s[F].big) begin
			v_mag = {1'b0, div_s[F].q};
			v_neg = div_s[F].neg;
		end else begin
			v_neg = div_s[F].xd[F+1];
			v_mag = v_neg ? (F + 1)'(-div_s[F].xd) : div_s[F].xd[F:0];
		end
		sq = v_mag * v_mag;
	end

	always_ff @(posedge clk) begin
		if (en[F+1]) begin
			ser_s[0].big <= div_s[F].big;
			ser_s[0].neg <= div_s[F].neg;
			ser_s[0].vneg <= v_neg;
			ser_s[0].pm <= v_mag;
			ser_s[0].v2 <= sq[2*F:F];
			ser_s[0].tm <= '0;
			ser_s[0].sum <= '0;
		end
	end

	for (genvar j = 1; j <= T + 1; j++) begin : g_ser
		logic [F:0] pm_next;
		logic [F:0] tm;
		logic signed [F+2:0] tv;
		logic signed [F+2:0] sum_next;
		ser_t ser_nxt;

		if (j <= T) begin : g_term
			localparam longint COEF = (((64'd2 << F) / (2 * (j - 1) + 1)) + 1) >> 1;

			atts_term #(
				.FRACTION_BITS (F),
				.COEF          (COEF)
			) u_term (
				.pm      (ser_s[j-1].pm),
				.v2      (ser_s[j-1].v2),
				.pm_next (pm_next),
				.tm      (tm)
			);
		end else begin : g_last
			assign pm_next = ser_s[j-1].pm;
			assign tm = '0;
		end

		always_comb begin
			tv = signed'({2'b00, ser_s[j-1].tm});
			if (j < 2) begin
				sum_next = '0;
			end else if (ser_s[j-1].vneg ^ (((j - 2) % 2) == 1)) begin
				sum_next = ser_s[j-1].sum - tv;
			end else begin
				sum_next = ser_s[j-1].sum + tv;
			end
			ser_nxt = ser_s[j-1];
			ser_nxt.pm = pm_next;
			ser_nxt.tm = tm;
			ser_nxt.sum = sum_next;
		end

		always_ff @(posedge clk) begin
			if (en[F+1+j]) begin
				ser_s[j] <= ser_nxt;
			end
		end
	end

	logic signed [EW-1:0] base_w;
	logic signed [EW-1:0] res_w;

	always_comb begin
		if (!ser_s[T+1].big) begin
			base_w = '0;
		end else if (ser_s[T+1].neg) begin
			base_w = -PI_W;
		end else begin
			base_w = PI_W;
		end
		res_w = ser_s[T+1].big ? base_w - EW'(ser_s[T+1].sum) : EW'(ser_s[T+1].sum);
	end

	always_ff @(posedge clk) begin
		if (en[L-1]) begin
			if (res_w > MAX_W) begin
				angle_q <= MAX_W[ANGLE_WIDTH-1:0];
			end else if (res_w < MIN_W) begin
				angle_q <= MIN_W[ANGLE_WIDTH-1:0];
			end else begin
				angle_q <= res_w[ANGLE_WIDTH-1:0];
			end
		end
	end

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the output stage is empty");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[F] && div_s[F].big |-> div_s[F].rem < div_s[F].mag)
		else $error("divider remainder reached the divisor");

	a_power_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[F+1] |-> ser_s[0].pm <= ONE_P && ser_s[0].v2 <= ONE_P)
		else $error("reduced argument exceeds one");

	a_sum_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[L-2] && !ser_s[T+1].vneg |->
			ser_s[T+1].sum >= 0 && ser_s[T+1].sum <= signed'({2'b00, ONE_P}))
		else $error("series sum left its range");
endmodule

// ===== design/atts_div_step.sv =====
// One restoring division step of the reciprocal, one quotient bit.
module atts_div_step (
	input  logic [atts_pkg::X_WIDTH:0] rem,
	input  logic [atts_pkg::X_WIDTH:0] mag,
	output logic [atts_pkg::X_WIDTH:0] rem_next,
	output logic                       qbit
);
	import atts_pkg::*;

	logic [X_WIDTH:0] shifted;

	always_comb begin
		shifted = {rem[X_WIDTH-1:0], 1'b0};
		qbit = (shifted >= mag);
		rem_next = qbit ? shifted - mag : shifted;
	end
endmodule

// ===== design/atts_term.sv =====
// Next power and coefficient product of one series term, both truncated.
module atts_term #(
	parameter int FRACTION_BITS = 16,
	parameter longint COEF = 65536
) (
	input  logic [FRACTION_BITS:0] pm,
	input  logic [FRACTION_BITS:0] v2,
	output logic [FRACTION_BITS:0] pm_next,
	output logic [FRACTION_BITS:0] tm
);
	import atts_pkg::*;

	localparam logic [FRACTION_BITS:0] C = (FRACTION_BITS + 1)'(COEF);

	logic [2*FRACTION_BITS+1:0] pw;
	logic [2*FRACTION_BITS+1:0] cw;

	always_comb begin
		pw = pm * v2;
		cw = C * pm;
		pm_next = pw[2*FRACTION_BITS:FRACTION_BITS];
		tm = cw[2*FRACTION_BITS:FRACTION_BITS];
	end
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the arctangent Taylor series unit.
`timescale 1ns / 1ps

class angle_scoreboard;
	logic [17:0] angle_queue[$];
	int errors;

	function longint prod_trunc(longint a, longint b);
		longint ma, mb, m;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		m = (ma * mb) >>> 16;
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function longint taylor_sum(longint v);
		longint v2, p, acc, c, t;
		v2 = prod_trunc(v, v);
		p = v;
		acc = 0;
		for (int i = 0; i < 10; i++) begin
			c = ((2 * 65536) / (2 * i + 1) + 1) >>> 1;
			t = prod_trunc(c, p);
			acc = (i % 2 == 1) ? acc - t : acc + t;
			p = prod_trunc(p, v2);
		end
		return acc;
	endfunction

	function logic [17:0] arctan_of(logic signed [31:0] xv);
		longint x, one, half_pi, r, res;
		one = 65536;
		half_pi = (atts_pkg::PI_HALF_Q32 + (64'sd1 <<< 15)) >>> 16;
		x = xv;
		if (x > one || x < -one) begin
			r = (one * one) / ((x < 0) ? -x : x);
			if (x < 0) res = -half_pi - taylor_sum(-r);
			else res = half_pi - taylor_sum(r);
		end else begin
			res = taylor_sum(x);
		end
		if (res > atts_pkg::ANGLE_MAX) res = atts_pkg::ANGLE_MAX;
		if (res < atts_pkg::ANGLE_MIN) res = atts_pkg::ANGLE_MIN;
		return res[17:0];
	endfunction

	function void note_argument(logic [31:0] xv);
		angle_queue.push_back(arctan_of(xv));
	endfunction

	task check_angle(logic [23:0] beat);
		logic [17:0] want;
		if (angle_queue.size() == 0) begin
			report_error($sformatf("unexpected angle %h", beat));
			return;
		end
		want = angle_queue.pop_front();
		if (beat[17:0] !== want)
			report_error($sformatf("angle %h, expected %h", beat[17:0], want));
		if (beat[23:18] !== 6'd0)
			report_error($sformatf("padding bits nonzero in %h", beat));
	endtask

	task report_error(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask
endclass

module testbench;
	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [31:0] s_tdata = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [23:0] m_tdata;
	angle_scoreboard board = new();
	int idle_cycles;
	bit inputs_done;

	arctangent_taylor_series_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	task send_argument(logic [31:0] xv);
		int gap;
		gap = $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= xv;
		do @(posedge clk); while (!s_tready);
		board.note_argument(xv);
	endtask

	function logic [31:0] random_argument();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 131072) - 65536;
			1: return $urandom_range(0, 2048) + 64512;
			2: return -($urandom_range(0, 2048) + 64512);
			3: return $urandom_range(0, 1 << 22) - (1 << 21);
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_angle(m_tdata);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				m_tready <= 0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		logic [31:0] directed[$];
		idle_cycles = 0;
		directed = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h10000, 32'hFFFF0000, 32'h10001,
			32'hFFFEFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'h8000, 32'hFFFF8000,
			32'hFFFF, 32'hFFFF0001, 32'h20000, 32'hFFFE0000, 32'h55555555, 32'hAAAAAAAA,
			32'h00FFFFFF, 32'hFF000000};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) send_argument(directed[i]);
		repeat (1850) send_argument(random_argument());
		s_tvalid <= 0;
		while (board.angle_queue.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/atts_pkg.sv
design/atts_div_step.sv
design/atts_term.sv
design/arctangent_taylor_series_unit.sv
sim/testbench.sv
